// ----- rtl/core/block_bitmap_allocator_macros.svh -----
// assertion macros for the bitmap block allocator
// expects clk and arst_n in the scope of each use
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

// property checked at every clock edge outside reset
`define BBA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// consequent checked in the cycle after the antecedent
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
	`BBA_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/bba_pkg.sv -----
// shared types, constants and helpers of the bitmap block allocator
// used by block_bitmap_allocator and the testbench, no dependencies
package bba_pkg;

	localparam int BITMAP_BYTES_DEF = 512;
	localparam int IDX_W            = 12;
	localparam int LEFT_W           = 13;

	localparam logic [7:0] BYTE_FULL = 8'hff;
	localparam logic [7:0] MSB_MASK  = 8'h80;

	// request codes carried in tuser
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE,
		ST_SCAN
	} state_t;

	// position of the first clear bit counted from the msb
	function automatic logic [2:0] first_clear(input logic [7:0] b);
		logic [2:0] pos;
		logic       found;
		pos   = 3'd0;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!found && !b[7 - i]) begin
				pos   = 3'(i);
				found = 1'b1;
			end
		end
		return pos;
	endfunction

endpackage

// ----- rtl/core/block_bitmap_allocator.sv -----
// bitmap block allocator, next fit, one result word per request word
// free: read the addressed byte, then clear the bit, write the byte back and emit the result;
// allocate: read the hint byte, then read on past each full byte, one lap at most, since the
// bitmap store has a single read port; zero-count allocate and out-of-range free answer without a read
// after reset a clearing pass writes zeros to every byte, no word taken meanwhile
// arst_n clears control state asynchronously; hint 0, free count at capacity
module block_bitmap_allocator #(
	parameter int BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // block_index [11:0], zero [15:12]
	input  logic        s_axis_tuser,  // cmd [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // granted_index [11:0], free_left [24:12], zero [31:25]
	output logic        m_axis_tuser   // ok [0]
);

	localparam int AW  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
	localparam int CAP = 8 * BITMAP_BYTES;
	localparam int CW  = $clog2(CAP + 1);
	localparam logic [AW-1:0] LAST_BYTE = AW'(BITMAP_BYTES - 1);

	bba_pkg::state_t state_q, state_d;

	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] hint_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] scan_n_q;
	logic [2:0]    bit_q;
	logic [11:0]   idx_q;
	logic [CW-1:0] count_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	logic          out_valid_q, out_ok_q;
	logic [11:0]   out_idx_q;
	logic [12:0]   out_left_q;

	logic          accept;
	logic          req_cmd;
	logic [11:0]   req_idx;
	logic          req_oor;
	logic [AW-1:0] req_byte;
	logic [31:0]   req_byte_ext;
	logic [AW-1:0] cur_next;
	logic [2:0]    pos;
	logic          byte_full;
	logic          count_zero;
	logic [CW-1:0] count_inc;

	logic          emit, emit_ok;
	logic [31:0]   emit_idx;
	logic [CW-1:0] emit_count;
	logic          count_we, hint_we, scan_step, start_scan, start_free;
	logic [CW-1:0] count_d;
	logic [31:0]   left_ext;

	// request decode
	assign req_cmd      = s_axis_tuser;
	assign req_idx      = s_axis_tdata[11:0];
	assign req_oor      = {20'd0, req_idx} >= 32'(CAP);
	assign req_byte_ext = {23'd0, req_idx[11:3]};
	assign req_byte     = req_byte_ext[AW-1:0];
	assign accept       = s_axis_tvalid && s_axis_tready;
	assign count_zero   = (count_q == '0);
	assign count_inc    = (count_q < CW'(CAP)) ? count_q + CW'(1) : count_q;
	assign byte_full    = (mem_rdata == bba_pkg::BYTE_FULL);
	assign pos          = bba_pkg::first_clear(mem_rdata);
	assign cur_next     = (cur_q == LAST_BYTE) ? '0 : cur_q + AW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_BYTE) state_d = bba_pkg::ST_IDLE;
			end
			bba_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_cmd == bba_pkg::CMD_FREE) begin
						if (!req_oor) state_d = bba_pkg::ST_FREE;
					end else if (!count_zero) begin
						state_d = bba_pkg::ST_SCAN;
					end
				end
			end
			bba_pkg::ST_FREE: state_d = bba_pkg::ST_IDLE;
			bba_pkg::ST_SCAN: begin
				if (!byte_full || scan_n_q == LAST_BYTE) state_d = bba_pkg::ST_IDLE;
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	// datapath control and result selection
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = cur_q;
		mem_wdata     = 8'd0;
		mem_re        = 1'b0;
		mem_raddr     = hint_q;
		emit          = 1'b0;
		emit_ok       = 1'b0;
		emit_idx      = 32'd0;
		emit_count    = count_q;
		count_we      = 1'b0;
		count_d       = count_q;
		hint_we       = 1'b0;
		scan_step     = 1'b0;
		start_scan    = 1'b0;
		start_free    = 1'b0;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			bba_pkg::ST_IDLE: begin
				s_axis_tready = !out_valid_q || m_axis_tready;
				if (accept) begin
					if (req_cmd == bba_pkg::CMD_FREE) begin
						if (req_oor) begin
							emit     = 1'b1;
							emit_idx = {20'd0, req_idx};
						end else begin
							mem_re     = 1'b1;
							mem_raddr  = req_byte;
							start_free = 1'b1;
						end
					end else if (count_zero) begin
						emit = 1'b1;
					end else begin
						mem_re     = 1'b1;
						mem_raddr  = hint_q;
						start_scan = 1'b1;
					end
				end
			end
			bba_pkg::ST_FREE: begin
				mem_we     = 1'b1;
				mem_wdata  = mem_rdata & ~(bba_pkg::MSB_MASK >> bit_q);
				count_we   = 1'b1;
				count_d    = count_inc;
				emit       = 1'b1;
				emit_ok    = 1'b1;
				emit_idx   = {20'd0, idx_q};
				emit_count = count_inc;
			end
			bba_pkg::ST_SCAN: begin
				if (!byte_full) begin
					mem_we     = 1'b1;
					mem_wdata  = mem_rdata | (bba_pkg::MSB_MASK >> pos);
					hint_we    = 1'b1;
					count_we   = 1'b1;
					count_d    = count_q - CW'(1);
					emit       = 1'b1;
					emit_ok    = 1'b1;
					emit_idx   = (32'(cur_q) << 3) | {29'd0, pos};
					emit_count = count_q - CW'(1);
				end else if (scan_n_q == LAST_BYTE) begin
					emit = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cur_next;
					scan_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign left_ext = 32'(emit_count);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bba_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			hint_q     <= '0;
			count_q    <= CW'(CAP);
		end else begin
			state_q <= state_d;
			if (state_q == bba_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + AW'(1);
			if (hint_we) hint_q <= cur_q;
			if (count_we) count_q <= count_d;
		end
	end

	// scan and free working registers
	always_ff @(posedge clk) begin
		if (start_scan) begin
			cur_q    <= hint_q;
			scan_n_q <= '0;
		end else if (scan_step) begin
			cur_q    <= cur_next;
			scan_n_q <= scan_n_q + AW'(1);
		end else if (start_free) begin
			cur_q <= req_byte;
			bit_q <= req_idx[2:0];
			idx_q <= req_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_idx_q  <= emit_idx[11:0];
			out_ok_q   <= emit_ok;
			out_left_q <= left_ext[12:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_left_q, out_idx_q};
	assign m_axis_tuser  = out_ok_q;

	bba_bitmap_mem #(
		.DEPTH(BITMAP_BYTES),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// checks
	`include "block_bitmap_allocator_macros.svh"

	`BBA_ASSERT(a_count_cap, count_q <= CW'(CAP), "free count above capacity")
	`BBA_ASSERT(a_emit_room, emit |-> (!out_valid_q || m_axis_tready), "result overwrites pending word")
	`BBA_ASSERT(a_clear_closed, state_q == bba_pkg::ST_CLEAR |-> !s_axis_tready, "word taken during clear")
	`BBA_ASSERT_NEXT(a_alloc_dec, state_q == bba_pkg::ST_SCAN && !byte_full, count_q == $past(count_q) - CW'(1), "allocate did not decrement count")

endmodule

// ----- rtl/core/bba_bitmap_mem.sv -----
// bitmap store: one write port, one read port with registered data
// depends on nothing but its parameters
module bba_bitmap_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/bba_checker.sv -----
`timescale 1ns / 1ps
// result checker for block_bitmap_allocator: keeps its own copy of the bitmap,
// predicts each result word and compares it field by field
// depends on bba_pkg for the request codes, byte constants and field widths
module bba_checker #(
	parameter int BYTES = bba_pkg::BITMAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // block_index [11:0], zero [15:12]
	input  logic        s_axis_tuser,  // cmd [0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // granted_index [11:0], free_left [24:12], zero [31:25]
	input  logic        m_axis_tuser,  // ok [0]
	output int          errors,
	output int          outstanding
);

	localparam int CAPACITY = BYTES * 8;
	localparam int IW       = bba_pkg::IDX_W;
	localparam int LW       = bba_pkg::LEFT_W;

	typedef struct packed {
		logic [IW-1:0] granted;
		logic          ok;
		logic [LW-1:0] left;
	} grant_t;

	logic [7:0]    used_map [BYTES];
	logic [IW-1:0] last_grant;
	logic [LW-1:0] blocks_free;
	grant_t        grant_q [$];

	// next-fit allocation or release of one block on the shadow state
	task automatic serve_request(input logic cmd, input logic [IW-1:0] idx,
			output grant_t res);
		int byte_at;
		int pos;
		bit found;
		if (cmd == bba_pkg::CMD_FREE) begin
			if (int'(idx) >= CAPACITY) begin
				res = '{idx, 1'b0, blocks_free};
			end else begin
				used_map[idx >> 3] &= ~(bba_pkg::MSB_MASK >> idx[2:0]);
				// freeing an already free block still bumps the count
				if (blocks_free < CAPACITY)
					blocks_free++;
				res = '{idx, 1'b1, blocks_free};
			end
		end else if (blocks_free == '0) begin
			res = '{'0, 1'b0, '0};
		end else begin
			byte_at = int'(last_grant >> 3);
			if (byte_at >= BYTES)
				byte_at = 0;
			// skip full bytes, one lap at most
			found = 1'b0;
			for (int n = 0; n < BYTES && !found; n++) begin
				if (used_map[byte_at] != bba_pkg::BYTE_FULL)
					found = 1'b1;
				else
					byte_at = (byte_at == BYTES - 1) ? 0 : byte_at + 1;
			end
			if (!found) begin
				res = '{'0, 1'b0, blocks_free};
			end else begin
				pos = 0;
				while (used_map[byte_at][7 - pos])
					pos++;
				used_map[byte_at] |= bba_pkg::MSB_MASK >> pos;
				last_grant = IW'(byte_at * 8 + pos);
				blocks_free--;
				res = '{last_grant, 1'b1, blocks_free};
			end
		end
	endtask

	// compare accepted result words first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin : watch
		grant_t want;
		grant_t got;
		if (!arst_n) begin
			for (int i = 0; i < BYTES; i++)
				used_map[i] = '0;
			last_grant  = '0;
			blocks_free = LW'(CAPACITY);
			grant_q.delete();
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[IW-1:0], m_axis_tuser, m_axis_tdata[IW +: LW]};
				if (grant_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual index %0d ok %0b left %0d",
						$time, got.granted, got.ok, got.left);
					errors++;
				end else begin
					want = grant_q.pop_front();
					if (got.granted !== want.granted) begin
						$display("%0t: granted_index expected %0d actual %0d",
							$time, want.granted, got.granted);
						errors++;
					end
					if (got.ok !== want.ok) begin
						$display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
						errors++;
					end
					if (got.left !== want.left) begin
						$display("%0t: free_left expected %0d actual %0d",
							$time, want.left, got.left);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				serve_request(s_axis_tuser, s_axis_tdata[IW-1:0], want);
				grant_q.push_back(want);
			end
			outstanding = grant_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for block_bitmap_allocator: clock, reset, request words,
// receiver stalls and the final verdict; checking is done in bba_checker
// depends on bba_pkg, block_bitmap_allocator and bba_checker
module tb_top;

	localparam int BYTES         = bba_pkg::BITMAP_BYTES_DEF;
	localparam int CAPACITY      = BYTES * 8;
	localparam int IW            = bba_pkg::IDX_W;
	localparam int RANDOM_WORDS  = 743;
	localparam int NO_IDLE_WORDS = 200;
	localparam int HOLD_CYCLES   = 300;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = bba_pkg::CMD_ALLOC;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	int   errors;
	int   outstanding;
	logic no_idle   = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt  = 0;

	always #5 clk = ~clk;

	block_bitmap_allocator #(
		.BITMAP_BYTES(BYTES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	bba_checker #(
		.BYTES(BYTES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	// receiver: random stalls, plus one long hold-off once requested
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt      <= hold_cnt - 1;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cnt      <= HOLD_CYCLES;
			hold_done     <= 1'b1;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 26);
		end
	end

	// offer one request word, starting and ending at a falling edge
	task automatic send_word(input logic cmd, input logic [IW-1:0] idx);
		while (!no_idle && $urandom_range(0, 99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'h0, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [IW-1:0] hot;
		int            pick;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// frees on an empty map saturate at capacity
		send_word(bba_pkg::CMD_FREE, IW'(CAPACITY - 1));
		send_word(bba_pkg::CMD_FREE, '0);
		// allocs from the bottom, then reuse of a hole below the last grant, inside the hint byte
		repeat (3) send_word(bba_pkg::CMD_ALLOC, '0);
		send_word(bba_pkg::CMD_FREE, IW'(1));
		send_word(bba_pkg::CMD_ALLOC, '1);

		// random mix, with frees clustered around a drifting spot
		// first stretch with no idling, long receiver hold-off halfway
		no_idle <= 1'b1;
		hot = IW'($urandom);
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == NO_IDLE_WORDS)
				no_idle <= 1'b0;
			if (i == RANDOM_WORDS / 2)
				hold_req <= 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				hot = IW'($urandom);
			if (pick < 40)
				send_word(bba_pkg::CMD_FREE, IW'($urandom));
			else if (pick < 55)
				send_word(bba_pkg::CMD_FREE, hot + IW'($urandom_range(0, 15)));
			else
				send_word(bba_pkg::CMD_ALLOC, IW'($urandom));
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for a full scan before the verdict
		while (outstanding != 0)
			@(negedge clk);
		repeat (BYTES + 8) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// run time guard
	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
